// File: src/fdsc_pkg.sv
package fdsc_pkg;

   localparam int CHAN_W   = 8;
   localparam int THRESH_W = 14;
   localparam int SUM_W    = 26;
   localparam int DIFF_W   = 10;
   localparam int FRAC_W   = 4;

   localparam logic [SUM_W-1:0]    SUM_MAX       = {SUM_W{1'b1}};
   localparam logic [THRESH_W-1:0] THRESH_RESET  = THRESH_W'(2640);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

endpackage

// File: src/frame_difference_scene_cut_core.sv
// Scene-cut detector: takes one RGB pixel per beat (tlast on the last pixel of a frame),
// compares it with the pixel at the same position of the previous frame held in an
// on-chip frame store of MAX_PIXELS entries, and adds up the absolute differences of
// red, green and blue. On each frame end it returns one beat with the frame's sum, a cut
// flag (sum * 16 > threshold * pixel count) and whether a reference frame existed; the
// first frame after reset never flags. Pixels past MAX_PIXELS are dropped but still
// end the frame. The block takes one pixel per cycle; the rate is set by the single
// read-first port of the frame store, read and written at the same address each beat.
// Once the beat with the last pixel is taken, the result passes the stage 1, stage 2 and
// output registers before rsp_tvalid rises. Input stalls only while a frame-end beat in
// stage 1 meets two results already waiting in stage 2 and the output register, until the
// output takes a beat. The threshold may be written only while the block is idle.
module frame_difference_scene_cut_core #(
   parameter int MAX_PIXELS = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // difference_sum[25:0], scene_cut[26],
                                                      // had_reference[27], zero[31:28]
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fdsc_pkg::THRESH_W-1:0] csr_wdata
);
   import fdsc_pkg::*;

   localparam int AW    = $clog2(MAX_PIXELS);
   localparam int PW    = $clog2(MAX_PIXELS + 1);
   localparam int PRODW = THRESH_W + PW;
   localparam int CMPW  = (SUM_W + FRAC_W > PRODW) ? SUM_W + FRAC_W : PRODW;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      abs_diff = (a > b) ? a - b : b - a;
   endfunction

   // configuration
   logic [THRESH_W-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid) begin
         thresh_ff <= csr_wdata;
      end
   end

   assign csr_ready = 1'b1;

   // input side
   pixel_type     pix;
   logic          req_accept;
   logic          in_range;
   logic [PW-1:0] pos_ff;
   logic          ref_valid_ff;
   pixel_type     old_pix;

   assign pix.red   = req_tdata[7:0];
   assign pix.green = req_tdata[15:8];
   assign pix.blue  = req_tdata[23:16];

   assign req_accept = req_tvalid && req_tready;
   assign in_range   = (pos_ff != PW'(MAX_PIXELS));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ref_valid_ff <= 1'b0;
      end else if (req_accept) begin
         if (req_tlast) begin
            pos_ff       <= '0;
            ref_valid_ff <= 1'b1;
         end else if (in_range) begin
            pos_ff <= pos_ff + PW'(1);
         end
      end
   end

   fdsc_frame_store #(
      .DEPTH(MAX_PIXELS)
   ) u_store (
      .clock  (clock),
      .en     (req_accept && in_range),
      .addr   (pos_ff[AW-1:0]),
      .wr_data(pix),
      .rd_data(old_pix)
   );

   // stage 1: difference and accumulate
   logic              s1_valid_ff;
   pixel_type         s1_pix_ff;
   logic              s1_use_ff;
   logic              s1_last_ff;
   logic              s1_had_ff;
   logic [PW-1:0]     s1_count_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic [DIFF_W-1:0] diff;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_sat;
   logic              s1_hold;
   logic              s1_fire;

   // stage 2 and output
   logic              s2_valid_ff;
   logic [SUM_W-1:0]  s2_sum_ff;
   logic [PRODW-1:0]  s2_prod_ff;
   logic              s2_had_ff;
   logic              s2_go;
   logic              out_free;
   logic              rsp_valid_ff;
   logic [SUM_W-1:0]  rsp_sum_ff;
   logic              rsp_cut_ff;
   logic              rsp_had_ff;
   logic              cut_in;

   assign diff = s1_use_ff ?
      DIFF_W'(abs_diff(s1_pix_ff.red,   old_pix.red))
    + DIFF_W'(abs_diff(s1_pix_ff.green, old_pix.green))
    + DIFF_W'(abs_diff(s1_pix_ff.blue,  old_pix.blue)) : '0;

   assign sum_wide = {1'b0, acc_ff} + (SUM_W + 1)'(diff);
   assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s2_go    = s2_valid_ff && out_free;
   assign s1_hold  = s1_valid_ff && s1_last_ff && s2_valid_ff && !s2_go;
   assign s1_fire  = s1_valid_ff && !s1_hold;

   // registered only: covers every case in which stage 1 could be held
   assign req_tready = !(s1_valid_ff && s1_last_ff && s2_valid_ff && rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept || s1_hold;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff   <= pix;
         s1_use_ff   <= in_range && ref_valid_ff;
         s1_last_ff  <= req_tlast;
         s1_had_ff   <= ref_valid_ff;
         s1_count_ff <= in_range ? pos_ff + PW'(1) : pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (s1_fire) begin
         acc_ff <= s1_last_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_fire && s1_last_ff) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_go) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         s2_sum_ff  <= sum_sat;
         s2_prod_ff <= PRODW'(thresh_ff) * PRODW'(s1_count_ff);
         s2_had_ff  <= s1_had_ff;
      end
   end

   // scaled sum against threshold times pixel count
   assign cut_in = s2_had_ff &&
                   (CMPW'({s2_sum_ff, {FRAC_W{1'b0}}}) > CMPW'(s2_prod_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         rsp_sum_ff <= s2_sum_ff;
         rsp_cut_ff <= cut_in;
         rsp_had_ff <= s2_had_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_had_ff, rsp_cut_ff, rsp_sum_ff};

`ifndef SYNTHESIS
   a_no_accept_on_hold: assert property (@(posedge clock) disable iff (reset)
      s1_hold |-> !req_accept)
      else $error("pixel accepted while stage 1 is held");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(MAX_PIXELS))
      else $error("pixel position beyond frame store");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> pos_ff == '0 && ref_valid_ff)
      else $error("frame end did not restart position");

   a_cut_needs_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cut_ff |-> rsp_had_ff)
      else $error("cut flagged without a reference frame");
`endif

endmodule

// File: src/fdsc_frame_store.sv
module fdsc_frame_store #(
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  fdsc_pkg::pixel_type      wr_data,
   output fdsc_pkg::pixel_type      rd_data
);
   import fdsc_pkg::*;

   pixel_type mem [0:DEPTH-1];
   pixel_type rd_data_ff;

   // read-first: the old pixel comes out while the new one goes in
   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
